/* sv/dro_pkg.sv */
// ----------------------------------------------------------------------------
// dro_pkg: shared types and constants for dead-reckoning odometry
// Fixed-point constants, CORDIC angle table, register indexes, state codes.
// ----------------------------------------------------------------------------
package dro_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] REG_TARGET_HEADING = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_TARGET_DISTANCE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_SPEED_COMMAND = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_COMMAND_ENABLE = 2'd3;

    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] QuarterPiQ30 = 36'sd843314857;
    localparam logic signed [35:0] CordicGainQ30 = 36'sd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_FOLD,
        ST_ROT,
        ST_MULX,
        ST_MULY,
        ST_CHECK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_rate;
        logic [19:0] time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading_out;
        logic turn_reached;
        logic distance_reached;
        logic signed [15:0] drive_speed;
        logic signed [31:0] steer_command;
        logic command_valid;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic a_signed;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0: atan_q30 = 30'd843314857;
            5'd1: atan_q30 = 30'd497837829;
            5'd2: atan_q30 = 30'd263043837;
            5'd3: atan_q30 = 30'd133525159;
            5'd4: atan_q30 = 30'd67021687;
            5'd5: atan_q30 = 30'd33543516;
            5'd6: atan_q30 = 30'd16775851;
            5'd7: atan_q30 = 30'd8388437;
            5'd8: atan_q30 = 30'd4194283;
            5'd9: atan_q30 = 30'd2097149;
            5'd31: atan_q30 = 30'd0;
            default: atan_q30 = 30'd1 << (5'd30 - i);
        endcase
    endfunction

endpackage

/* sv/dro_stream_if.sv */
// ----------------------------------------------------------------------------
// dro_stream_if: valid/ready channel
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dro_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/dro_serial_mul.sv */
// ----------------------------------------------------------------------------
// dro_serial_mul: shift-add multiplier
// Consumes one bit of the multiplier b per cycle; a is signed or unsigned,
// b is signed two's complement of width BW.
// ----------------------------------------------------------------------------
module dro_serial_mul #(
    parameter int unsigned AW = 32,
    parameter int unsigned BW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dro_pkg::t_mul_ctl         i_ctl,
    input  logic [AW-1:0]             i_a,
    input  logic [BW-1:0]             i_b,
    output dro_pkg::t_mul_sts         o_sts,
    output logic signed [AW+BW:0]     o_p
);
    import dro_pkg::*;

    localparam int unsigned CntW = $clog2(BW + 1);

    logic signed [AW+BW:0] r_acc, n_acc;
    logic signed [AW+BW:0] r_a, n_a;
    logic [BW-1:0]         r_b, n_b;
    logic [CntW-1:0]       r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_acc  = '0;
            n_a    = i_ctl.a_signed ? (AW+BW+1)'(signed'(i_a)) : (AW+BW+1)'({1'b0, i_a});
            n_b    = i_b;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                if (r_cnt == CntW'(BW - 1)) n_acc = r_acc - r_a;
                else n_acc = r_acc + r_a;
            end
            n_a   = r_a <<< 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(BW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_p        = r_acc;
endmodule

/* sv/dro_cordic.sv */
// ----------------------------------------------------------------------------
// dro_cordic: quadrant fold and iterative CORDIC rotation
// Folds by quarter turns one per cycle, then one rotation step per cycle.
// ----------------------------------------------------------------------------
module dro_cordic #(
    parameter int unsigned ROTATION_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_heading,
    output logic                o_done,
    output logic signed [35:0]  o_cos,
    output logic signed [35:0]  o_sin
);
    import dro_pkg::*;

    logic signed [35:0] r_r, n_r;
    logic signed [35:0] r_x, n_x;
    logic signed [35:0] r_y, n_y;
    logic [1:0]         r_k, n_k;
    logic [4:0]         r_i, n_i;
    logic               r_fold, n_fold;
    logic               r_rot, n_rot;
    logic               r_done, n_done;

    always_comb begin
        n_r = r_r; n_x = r_x; n_y = r_y; n_k = r_k; n_i = r_i;
        n_fold = r_fold; n_rot = r_rot; n_done = 1'b0;
        if (i_start) begin
            n_r = 36'(i_heading) <<< 2;
            n_x = CordicGainQ30;
            n_y = '0;
            n_k = '0;
            n_i = '0;
            n_fold = 1'b1;
            n_rot = 1'b0;
        end else if (r_fold) begin
            if (r_r > QuarterPiQ30) begin
                n_r = r_r - HalfPiQ30;
                n_k = r_k + 2'd1;
            end else if (r_r < -QuarterPiQ30) begin
                n_r = r_r + HalfPiQ30;
                n_k = r_k - 2'd1;
            end else begin
                n_fold = 1'b0;
                n_rot  = 1'b1;
            end
        end else if (r_rot) begin
            if (!r_r[35]) begin
                n_x = r_x - (r_y >>> r_i);
                n_y = r_y + (r_x >>> r_i);
                n_r = r_r - 36'(atan_q30(r_i));
            end else begin
                n_x = r_x + (r_y >>> r_i);
                n_y = r_y - (r_x >>> r_i);
                n_r = r_r + 36'(atan_q30(r_i));
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(ROTATION_STEPS - 1)) begin
                n_rot  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r; r_x <= n_x; r_y <= n_y; r_k <= n_k; r_i <= n_i;
        if (!i_rst_n) begin
            r_fold <= 1'b0;
            r_rot  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fold <= n_fold;
            r_rot  <= n_rot;
            r_done <= n_done;
        end
    end

    always_comb begin
        case (r_k)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;
endmodule

/* sv/dead_reckoning_odometry.sv */
// ----------------------------------------------------------------------------
// dead_reckoning_odometry: fixed-point dead-reckoning pose estimator
// Integrates heading and position from speed samples, CORDIC sin/cos.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  i_in      in   linear_speed, angular_rate, time_step
//  o_out     out  pos, heading, flags, commands
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
//
//  One sample at a time. A first sample goes straight to the check and
//  output states. A later one runs the heading multiply, the CORDIC fold
//  and ROTATION_STEPS rotation steps, then x and y in turn (speed times
//  trig, times time step, square): seven 36-bit multiplies on one shared
//  bit-serial multiplier, then check and output. The result waits in an
//  output register; a new sample is taken once the previous result has
//  left. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module dead_reckoning_odometry #(
    parameter int unsigned ROTATION_STEPS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dro_stream_if.sink                       i_in,
    dro_stream_if.source                     o_out,
    input  logic                             i_cfg_we,
    input  logic [dro_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [dro_pkg::CfgDataW-1:0]     i_cfg_data
);
    import dro_pkg::*;

    // multiplier: a 36 bit, b 36 bit signed
    localparam int unsigned MAW = 36;
    localparam int unsigned MBW = 36;

    logic [28:0]        r_tgt_head;
    logic [30:0]        r_tgt_dist;
    logic signed [15:0] r_spd_cmd;
    logic               r_cmd_en;

    t_state r_state, n_state;
    logic   r_first;
    logic   r_turn, r_dist;
    logic signed [31:0] r_x, r_y, r_h;
    t_in_beat r_in;
    logic [2:0] r_sub;
    logic signed [35:0] r_c, r_s;
    logic signed [63:0] r_d2;
    t_out_beat r_out;
    logic r_ovalid;

    t_mul_ctl mctl;
    t_mul_sts msts;
    logic [MAW-1:0] m_a;
    logic [MBW-1:0] m_b;
    logic signed [MAW+MBW:0] m_p;
    logic cor_start, cor_done;
    logic signed [35:0] cor_c, cor_s;

    dro_serial_mul #(.AW(MAW), .BW(MBW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(mctl),
        .i_a(m_a), .i_b(m_b), .o_sts(msts), .o_p(m_p)
    );

    dro_cordic #(.ROTATION_STEPS(ROTATION_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_heading(r_h), .o_done(cor_done), .o_cos(cor_c), .o_sin(cor_s)
    );

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) sat32 = 32'sh7FFFFFFF;
        else if (v < -38'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    logic in_acc, out_acc;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // sub-steps of the serial work
    localparam logic [2:0] SUB_START = 3'd0;
    localparam logic [2:0] SUB_WAIT  = 3'd1;

    logic [63:0] ah100, th99, th101;
    logic [31:0] ah;
    assign ah    = r_h[31] ? 32'(-r_h) : 32'(r_h);
    // small constant multiplies fit with shifts/adds
    assign ah100 = 64'(ah) * 64'd100;
    assign th99  = 64'(r_tgt_head) * 64'd99;
    assign th101 = 64'(r_tgt_head) * 64'd101;

    // phase within ST_MULX / ST_MULY: 0 speed*trig, 1 *dt, 2 square
    logic [1:0] r_ph, n_ph;
    logic signed [35:0] r_v, n_v;
    logic signed [63:0] n_d2;
    logic signed [31:0] n_x, n_y, n_h;
    logic n_turn, n_dist, n_first;
    logic [2:0] n_sub;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = r_first ? ST_CHECK : ST_HEAD;
            ST_HEAD:  if (msts.done) n_state = ST_FOLD;
            ST_FOLD:  n_state = ST_ROT;
            ST_ROT:   if (cor_done) n_state = ST_MULX;
            ST_MULX:  if (msts.done && r_ph == 2'd2) n_state = ST_MULY;
            ST_MULY:  if (msts.done && r_ph == 2'd2) n_state = ST_CHECK;
            ST_CHECK: n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mctl = '0;
        m_a = '0;
        m_b = '0;
        cor_start = 1'b0;
        n_ph = r_ph; n_v = r_v; n_d2 = r_d2;
        n_x = r_x; n_y = r_y; n_h = r_h;
        n_turn = r_turn; n_dist = r_dist; n_first = r_first;
        n_sub = r_sub;
        unique case (r_state)
            ST_IDLE: begin
                n_sub = SUB_START;
                n_ph = 2'd0;
                n_d2 = '0;
                if (in_acc && r_first) begin
                    n_first = 1'b0;
                    n_x = '0; n_y = '0; n_h = '0;
                end
            end
            ST_HEAD: begin
                m_a = MAW'(signed'(r_in.angular_rate));
                m_b = MBW'({1'b0, r_in.time_step});
                if (r_sub == SUB_START) begin
                    mctl.start = 1'b1; mctl.a_signed = 1'b1; n_sub = SUB_WAIT;
                end
                if (msts.done) begin
                    n_h = sat32(38'(r_h) + 38'(m_p >>> 4));
                    n_sub = SUB_START;
                end
            end
            ST_FOLD: cor_start = 1'b1;
            ST_ROT: begin
                n_sub = SUB_START;
                n_ph = 2'd0;
            end
            ST_MULX, ST_MULY: begin
                mctl.a_signed = 1'b1;
                unique case (r_ph)
                    2'd0: begin
                        m_a = MAW'(signed'(r_in.linear_speed));
                        m_b = (r_state == ST_MULX) ? r_c : r_s;
                    end
                    2'd1: begin
                        m_a = r_v;
                        m_b = MBW'({1'b0, r_in.time_step});
                    end
                    default: begin
                        m_a = (r_state == ST_MULX) ? MAW'(r_x) : MAW'(r_y);
                        m_b = (r_state == ST_MULX) ? MBW'(r_x) : MBW'(r_y);
                    end
                endcase
                if (r_sub == SUB_START) begin
                    mctl.start = 1'b1; n_sub = SUB_WAIT;
                end
                if (msts.done) begin
                    n_sub = SUB_START;
                    n_ph = r_ph + 2'd1;
                    unique case (r_ph)
                        2'd0: n_v = 36'(m_p >>> 14);
                        2'd1: begin
                            if (r_state == ST_MULX)
                                n_x = sat32(38'(r_x) + 38'(m_p >>> 32));
                            else
                                n_y = sat32(38'(r_y) + 38'(m_p >>> 32));
                        end
                        default: begin
                            n_d2 = r_d2 + 64'(m_p);
                            n_ph = 2'd0;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (ah100 >= th99 && ah100 <= th101) n_turn = 1'b1;
                if (64'(r_d2) > 64'(r_tgt_dist) * 64'(r_tgt_dist)) n_dist = 1'b1;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_d2 <= n_d2;
        if (in_acc) r_in <= i_in.data;
        if (cor_done) begin
            r_c <= cor_c;
            r_s <= cor_s;
        end
        if (r_state == ST_OUT) begin
            r_out.pos_x <= r_x;
            r_out.pos_y <= r_y;
            r_out.heading_out <= r_h;
            r_out.turn_reached <= r_turn;
            r_out.distance_reached <= r_dist;
            r_out.drive_speed <= r_spd_cmd;
            r_out.steer_command <= (r_h == 32'sh80000000) ? 32'sh7FFFFFFF : -r_h;
            r_out.command_valid <= r_cmd_en;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 1'b1;
            r_turn <= 1'b0;
            r_dist <= 1'b0;
            r_x <= '0; r_y <= '0; r_h <= '0;
            r_sub <= SUB_START;
            r_ph <= '0;
            r_ovalid <= 1'b0;
            r_tgt_head <= '0;
            r_tgt_dist <= '0;
            r_spd_cmd <= '0;
            r_cmd_en <= 1'b1;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_turn <= n_turn;
            r_dist <= n_dist;
            r_x <= n_x; r_y <= n_y; r_h <= n_h;
            r_sub <= n_sub;
            r_ph <= n_ph;
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
            else if (out_acc) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TARGET_HEADING:  r_tgt_head <= i_cfg_data[28:0];
                    REG_TARGET_DISTANCE: r_tgt_dist <= i_cfg_data[30:0];
                    REG_SPEED_COMMAND:   r_spd_cmd <= i_cfg_data[15:0];
                    REG_COMMAND_ENABLE:  r_cmd_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_acc) else $error("accept while busy");
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_OUT) else $error("stray result");
    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_turn) && $past(i_rst_n) |-> r_turn) else $error("flag cleared");
`endif
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for dead_reckoning_odometry
// Drives velocity samples through a directed table and then random phases
// under several register settings. Each input beat is run through a local
// pose integrator (heading, CORDIC sin/cos, saturating x/y, sticky flags) and
// every output beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import dro_pkg::*;

    localparam int unsigned NSTEPS = 24;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint QTR_PI = 64'sd843314857;
    localparam longint GAIN = 64'sd652032874;
    localparam int PHASES = 6;
    localparam int PHASE_BEATS = 72;

    typedef struct packed {
        logic      typed;
        t_in_beat  beat;
        t_out_beat pose;
    } t_row;

    localparam int NROWS = 16;
    // typed rows: first sample zeroes pose with default registers
    localparam t_row DIRECTED[NROWS] = '{
        '{1'b1, '{16'h7fff, 16'h8000, 20'hfffff},
            '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 16'd0, 32'd0, 1'b1}},
        '{1'b1, '{16'h0000, 16'h0000, 20'h00000},
            '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 16'd0, 32'd0, 1'b1}},
        '{1'b0, '{16'h7fff, 16'h0000, 20'hfffff}, '0},
        '{1'b0, '{16'h8000, 16'h0000, 20'hfffff}, '0},
        '{1'b0, '{16'h7fff, 16'h7fff, 20'hfffff}, '0},
        '{1'b0, '{16'h7fff, 16'h7fff, 20'hfffff}, '0},
        '{1'b0, '{16'h8000, 16'h8000, 20'hfffff}, '0},
        '{1'b0, '{16'h8000, 16'h8000, 20'hfffff}, '0},
        '{1'b0, '{16'h8000, 16'h8000, 20'hfffff}, '0},
        '{1'b0, '{16'h8000, 16'h8000, 20'hfffff}, '0},
        '{1'b0, '{16'h1234, 16'hffff, 20'h00001}, '0},
        '{1'b0, '{16'hffff, 16'h0001, 20'h80000}, '0},
        '{1'b0, '{16'h4000, 16'h3243, 20'h40000}, '0},
        '{1'b0, '{16'h8000, 16'h7fff, 20'h00000}, '0},
        '{1'b0, '{16'h0001, 16'hcdbd, 20'h7ffff}, '0},
        '{1'b0, '{16'h5555, 16'haaaa, 20'h55555}, '0}
    };

    localparam longint ATAN[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    dro_stream_if #(.T(t_in_beat)) in_if ();
    dro_stream_if #(.T(t_out_beat)) out_if ();

    dead_reckoning_odometry #(.ROTATION_STEPS(NSTEPS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of pose state and registers
    longint tgt_head, tgt_dist, spd_cmd;
    bit     cmd_en;
    bit     fresh;
    longint head_acc, x_acc, y_acc;
    bit     turn_hit, dist_hit;

    t_out_beat pose_q[$];
    t_row      typed_q[$];
    int        errors;
    bit        long_hold;
    bit        calm;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void cordic_sincos(longint hd, output longint c, output longint s);
        longint r, k, x, y, nx;
        r = hd * 4;
        k = 0;
        x = GAIN;
        y = 0;
        while (r > QTR_PI) begin
            r -= HALF_PI;
            k++;
        end
        while (r < -QTR_PI) begin
            r += HALF_PI;
            k--;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r -= ATAN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r += ATAN[i];
            end
            x = nx;
        end
        case (k & 3)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_out_beat integrate_pose(t_in_beat b);
        longint spd, rate, dt, c, s, ah;
        longint unsigned d2, t2;
        t_out_beat o;
        spd = longint'(b.linear_speed);
        rate = longint'(b.angular_rate);
        dt = longint'(b.time_step);
        if (fresh) begin
            fresh = 0;
            x_acc = 0;
            y_acc = 0;
            head_acc = 0;
        end else begin
            head_acc = clamp32(head_acc + ((rate * dt) >>> 4));
            cordic_sincos(head_acc, c, s);
            x_acc = clamp32(x_acc + ((((spd * c) >>> 14) * dt) >>> 32));
            y_acc = clamp32(y_acc + ((((spd * s) >>> 14) * dt) >>> 32));
        end
        ah = head_acc < 0 ? -head_acc : head_acc;
        if (ah * 100 >= tgt_head * 99 && ah * 100 <= tgt_head * 101) turn_hit = 1;
        d2 = longint'(x_acc * x_acc) + longint'(y_acc * y_acc);
        t2 = tgt_dist * tgt_dist;
        if (d2 > t2) dist_hit = 1;
        o.pos_x = x_acc[31:0];
        o.pos_y = y_acc[31:0];
        o.heading_out = head_acc[31:0];
        o.turn_reached = turn_hit;
        o.distance_reached = dist_hit;
        o.drive_speed = spd_cmd[15:0];
        o.steer_command = (head_acc == -64'sd2147483648) ? 32'h7fffffff : 32'(-head_acc);
        o.command_valid = cmd_en;
        return o;
    endfunction

    function automatic void cmp_field(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
            errors++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // input acceptance: run the integrator
    always @(posedge i_clk) begin
        t_out_beat p;
        t_row row;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            p = integrate_pose(in_if.data);
            if (typed_q.size() > 0) begin
                row = typed_q.pop_front();
                if (row.typed) p = row.pose;
            end
            pose_q.push_back(p);
        end
    end

    // output acceptance: compare with oldest prediction
    always @(posedge i_clk) begin
        t_out_beat e, a;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            a = out_if.data;
            if (pose_q.size() == 0) begin
                $display("%0t unexpected beat: expected none actual x=%0d", $time,
                         a.pos_x);
                errors++;
            end else begin
                e = pose_q.pop_front();
                cmp_field("pos_x", e.pos_x, a.pos_x);
                cmp_field("pos_y", e.pos_y, a.pos_y);
                cmp_field("heading_out", e.heading_out, a.heading_out);
                cmp_field("turn_reached", e.turn_reached, a.turn_reached);
                cmp_field("distance_reached", e.distance_reached, a.distance_reached);
                cmp_field("drive_speed", e.drive_speed, a.drive_speed);
                cmp_field("steer_command", e.steer_command, a.steer_command);
                cmp_field("command_valid", e.command_valid, a.command_valid);
            end
        end
    end

    // result sink with random backpressure and one long hold-off
    initial begin
        int gap;
        out_if.ready <= 0;
        forever begin
            if (long_hold) begin
                out_if.ready <= 0;
                repeat (600) @(posedge i_clk);
                long_hold = 0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    out_if.ready <= 1;
                    @(posedge i_clk);
                end else begin
                    out_if.ready <= 0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_sample(t_in_beat b);
        int gap;
        in_if.valid <= 1;
        in_if.data <= b;
        do @(posedge i_clk); while (!in_if.ready);
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (in_if.valid) begin
            in_if.valid <= 0;
            @(posedge i_clk);
        end
        while (pose_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_regs(longint h, longint d, longint sp, bit en);
        logic [CfgDataW-1:0] w;
        drain();
        repeat (200) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    w = 31'(h) | (31'($urandom_range(0, 3)) << 29);
                    i_cfg_idx <= REG_TARGET_HEADING;
                    tgt_head = longint'(w[28:0]);
                end
                1: begin
                    w = 31'(d);
                    i_cfg_idx <= REG_TARGET_DISTANCE;
                    tgt_dist = longint'(w);
                end
                2: begin
                    w = {15'($urandom), 16'(sp)};
                    i_cfg_idx <= REG_SPEED_COMMAND;
                    spd_cmd = longint'($signed(w[15:0]));
                end
                default: begin
                    w = {30'($urandom), en};
                    i_cfg_idx <= REG_COMMAND_ENABLE;
                    cmd_en = w[0];
                end
            endcase
            i_cfg_we <= 1;
            i_cfg_data <= w;
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic t_in_beat rand_sample();
        t_in_beat b;
        int kind;
        kind = $urandom_range(0, 9);
        b.linear_speed = 16'($urandom);
        if (kind < 2) begin
            b.angular_rate = 16'($urandom);
            b.time_step = 20'($urandom);
        end else begin
            b.angular_rate = 16'($urandom_range(0, 8191) - 4096);
            b.time_step = 20'($urandom_range(0, 20000));
        end
        return b;
    endfunction

    initial begin
        longint h, d, sp;
        bit en;
        errors = 0;
        long_hold = 0;
        calm = 0;
        tgt_head = 0;
        tgt_dist = 0;
        spd_cmd = 0;
        cmd_en = 1;
        fresh = 1;
        head_acc = 0;
        x_acc = 0;
        y_acc = 0;
        turn_hit = 0;
        dist_hit = 0;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_if.valid <= 0;
        in_if.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int n = 0; n < NROWS; n++) begin
            typed_q.push_back(DIRECTED[n]);
            send_sample(DIRECTED[n].beat);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin h = 421657428; d = 2147483647; sp = 32767; en = 0; end
                1: begin h = 0; d = 0; sp = -32768; en = 1; end
                default: begin
                    h = $urandom_range(0, 421657428);
                    d = $urandom_range(0, 40000000);
                    sp = longint'($urandom_range(0, 65535)) - 32768;
                    en = $urandom_range(0, 1);
                end
            endcase
            write_regs(h, d, sp, en);
            calm = (p == 3);
            if (p == 2) long_hold = 1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 4 && n == 30) drain();
                send_sample(rand_sample());
            end
        end
        calm = 0;

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
